>>> rtl/core/skat_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the sorted key/address table.
// Used by skat_cell, skat_ctrl, the top level and the checker; depends on nothing.
package skat_pkg;

    // Table geometry
    localparam int CAPACITY = 64;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int KEY_W    = 32;
    localparam int ADDR_W   = 64;
    localparam int CFG_W    = 7;
    localparam int LIM_W    = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam int STAT_W   = 3;
    localparam int OCNT_W   = 7;

    // Stream payload widths
    localparam int S_DATA_W = 96;
    localparam int M_DATA_W = 80;

    // Configuration port
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;
    localparam logic [PADDR_W-3:0] REG_MAX_ENTRIES = 1'b0;
    localparam logic [CFG_W-1:0]   MAX_ENTRIES_RST = 7'd64;

    // Action codes
    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_LOOKUP = 1'b1;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK      = 3'd0;
    localparam logic [STAT_W-1:0] ST_FULL    = 3'd1;
    localparam logic [STAT_W-1:0] ST_DUP     = 3'd2;
    localparam logic [STAT_W-1:0] ST_EMPTY   = 3'd3;
    localparam logic [STAT_W-1:0] ST_MISSING = 3'd4;

    // Kind of token riding down the cell chain
    typedef enum logic [2:0] {
        TK_IDLE,
        TK_INSERT,
        TK_SHIFT,
        TK_LOOKUP,
        TK_DONE
    } tok_kind_t;

    // Token handed from cell to cell
    typedef struct packed {
        tok_kind_t           kind;
        logic                is_insert;
        logic [STAT_W-1:0]   status;
        logic [KEY_W-1:0]    key;
        logic [ADDR_W-1:0]   addr;
        logic [CNT_W-1:0]    remain;
    } tok_t;

    // Finished result
    typedef struct packed {
        logic [OCNT_W-1:0]   count;
        logic [ADDR_W-1:0]   found;
        logic [STAT_W-1:0]   status;
    } res_t;

endpackage

>>> rtl/core/skat_cell.sv
`timescale 1ns / 1ps
// One table slot: holds a key/address pair and processes the token passing by.
// Depends on skat_pkg.
module skat_cell (
    input  logic            aclk,
    input  logic            aresetn,
    input  skat_pkg::tok_t  tok_i,
    output skat_pkg::tok_t  tok_o
);

    logic [skat_pkg::KEY_W-1:0]  key_reg;
    logic [skat_pkg::ADDR_W-1:0] addr_reg;
    skat_pkg::tok_t              tok_reg;
    skat_pkg::tok_t              tok_next;
    logic                        wr_en;
    logic                        occupied;
    logic                        key_eq;
    logic                        key_lt;
    logic [skat_pkg::CNT_W-1:0]  rem_dec;

    assign occupied = (tok_i.remain != '0);
    assign key_eq   = (key_reg == tok_i.key);
    assign key_lt   = (key_reg < tok_i.key);
    assign rem_dec  = tok_i.remain - skat_pkg::CNT_W'(1);

    // Decide what this slot does with the incoming token
    always_comb begin
        tok_next = tok_i;
        wr_en    = 1'b0;
        case (tok_i.kind)
            skat_pkg::TK_INSERT: begin
                if (occupied && key_eq) begin
                    tok_next.kind   = skat_pkg::TK_DONE;
                    tok_next.status = skat_pkg::ST_DUP;
                    tok_next.addr   = '0;
                end else if (occupied && key_lt) begin
                    tok_next.remain = rem_dec;
                end else begin
                    // Take the new pair; push the old one up the chain
                    wr_en = 1'b1;
                    if (occupied) begin
                        tok_next.kind   = skat_pkg::TK_SHIFT;
                        tok_next.key    = key_reg;
                        tok_next.addr   = addr_reg;
                        tok_next.remain = rem_dec;
                    end else begin
                        tok_next.kind   = skat_pkg::TK_DONE;
                        tok_next.status = skat_pkg::ST_OK;
                        tok_next.addr   = '0;
                    end
                end
            end
            skat_pkg::TK_SHIFT: begin
                wr_en = 1'b1;
                if (occupied) begin
                    tok_next.key    = key_reg;
                    tok_next.addr   = addr_reg;
                    tok_next.remain = rem_dec;
                end else begin
                    tok_next.kind   = skat_pkg::TK_DONE;
                    tok_next.status = skat_pkg::ST_OK;
                    tok_next.addr   = '0;
                end
            end
            skat_pkg::TK_LOOKUP: begin
                if (occupied && key_eq) begin
                    tok_next.kind   = skat_pkg::TK_DONE;
                    tok_next.status = skat_pkg::ST_OK;
                    tok_next.addr   = addr_reg;
                end else if (occupied && key_lt && (rem_dec != '0)) begin
                    tok_next.remain = rem_dec;
                end else begin
                    // Past the key or past the last entry: no match
                    tok_next.kind   = skat_pkg::TK_DONE;
                    tok_next.status = skat_pkg::ST_MISSING;
                    tok_next.addr   = '0;
                end
            end
            default: begin
                tok_next = tok_i;
            end
        endcase
    end

    // Hold the slot contents
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            key_reg  <= tok_i.key;
            addr_reg <= tok_i.addr;
        end
    end

    // Advance the token to the next slot
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg.kind <= skat_pkg::TK_IDLE;
        end else begin
            tok_reg.kind <= tok_next.kind;
        end
        tok_reg.is_insert <= tok_next.is_insert;
        tok_reg.status    <= tok_next.status;
        tok_reg.key       <= tok_next.key;
        tok_reg.addr      <= tok_next.addr;
        tok_reg.remain    <= tok_next.remain;
    end

    assign tok_o = tok_reg;

endmodule

>>> rtl/core/skat_ctrl.sv
`timescale 1ns / 1ps
// Front end and result stage: accepts items, launches tokens into the cell chain,
// keeps the entry count and limit register, and buffers results. Depends on skat_pkg.
module skat_ctrl (
    input  logic                             aclk,
    input  logic                             aresetn,
    // Input item
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [skat_pkg::S_DATA_W-1:0]    s_tdata,
    input  logic                             s_tuser,
    // Result item
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [skat_pkg::M_DATA_W-1:0]    m_tdata,
    // Configuration
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [skat_pkg::PADDR_W-1:0]     paddr,
    input  logic [skat_pkg::PDATA_W-1:0]     pwdata,
    output logic [skat_pkg::PDATA_W-1:0]     prdata,
    output logic                             pready,
    // Cell chain ends
    output skat_pkg::tok_t                   launch_o,
    input  skat_pkg::tok_t                   tok_end_i
);

    logic                          busy_reg;
    logic [skat_pkg::CNT_W-1:0]    count_reg;
    logic [skat_pkg::CFG_W-1:0]    max_reg;
    skat_pkg::tok_t                launch_reg;
    skat_pkg::tok_t                launch_next;
    logic                          out_valid_reg;
    skat_pkg::res_t                out_reg;
    logic                          skid_valid_reg;
    skat_pkg::res_t                skid_reg;

    logic                          accept;
    logic                          cfg_wr;
    logic [skat_pkg::LIM_W-1:0]    limit;
    logic                          is_full;
    logic                          res_valid;
    logic                          res_inc;
    logic [skat_pkg::CNT_W-1:0]    count_next;
    skat_pkg::res_t                res;
    logic                          take;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = !busy_reg && !skid_valid_reg;
    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && pready &&
                      (paddr[skat_pkg::PADDR_W-1:2] == skat_pkg::REG_MAX_ENTRIES);

    // Register read
    assign prdata = (paddr[skat_pkg::PADDR_W-1:2] == skat_pkg::REG_MAX_ENTRIES) ?
                    skat_pkg::PDATA_W'(max_reg) : '0;

    // Effective limit is the register clamped to the table size
    assign limit = (skat_pkg::LIM_W'(max_reg) > skat_pkg::LIM_W'(skat_pkg::CAPACITY)) ?
                   skat_pkg::LIM_W'(skat_pkg::CAPACITY) : skat_pkg::LIM_W'(max_reg);
    assign is_full = (skat_pkg::LIM_W'(count_reg) >= limit) ||
                     (count_reg >= skat_pkg::CNT_W'(skat_pkg::CAPACITY));

    // Build the token for an accepted item
    always_comb begin
        launch_next.kind      = skat_pkg::TK_IDLE;
        launch_next.is_insert = (s_tuser == skat_pkg::ACT_INSERT);
        launch_next.status    = skat_pkg::ST_OK;
        launch_next.key       = s_tdata[skat_pkg::KEY_W-1:0];
        launch_next.addr      = s_tdata[skat_pkg::KEY_W +: skat_pkg::ADDR_W];
        launch_next.remain    = count_reg;
        if (accept) begin
            if (s_tuser == skat_pkg::ACT_INSERT) begin
                if (is_full) begin
                    launch_next.kind   = skat_pkg::TK_DONE;
                    launch_next.status = skat_pkg::ST_FULL;
                    launch_next.addr   = '0;
                end else begin
                    launch_next.kind   = skat_pkg::TK_INSERT;
                end
            end else begin
                if (count_reg == '0) begin
                    launch_next.kind   = skat_pkg::TK_DONE;
                    launch_next.status = skat_pkg::ST_EMPTY;
                    launch_next.addr   = '0;
                end else begin
                    launch_next.kind   = skat_pkg::TK_LOOKUP;
                end
            end
        end
    end

    // Result leaving the end of the chain
    assign res_valid  = (tok_end_i.kind == skat_pkg::TK_DONE);
    assign res_inc    = tok_end_i.is_insert && (tok_end_i.status == skat_pkg::ST_OK);
    assign count_next = count_reg + skat_pkg::CNT_W'(res_inc);
    assign res.status = tok_end_i.status;
    assign res.found  = tok_end_i.addr;
    assign res.count  = skat_pkg::OCNT_W'(count_next);
    assign take       = out_valid_reg && m_tready;

    // Control state: busy flag, count, limit, launch token, output valids
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg         <= 1'b0;
            count_reg        <= '0;
            max_reg          <= skat_pkg::MAX_ENTRIES_RST;
            launch_reg.kind  <= skat_pkg::TK_IDLE;
            out_valid_reg    <= 1'b0;
            skid_valid_reg   <= 1'b0;
        end else begin
            launch_reg.kind <= launch_next.kind;
            if (cfg_wr) begin
                max_reg <= pwdata[skat_pkg::CFG_W-1:0];
            end
            if (accept) begin
                busy_reg <= 1'b1;
            end else if (res_valid) begin
                busy_reg  <= 1'b0;
                count_reg <= count_next;
            end
            if (!out_valid_reg || take) begin
                if (skid_valid_reg) begin
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end else begin
                    out_valid_reg  <= res_valid;
                end
            end else if (res_valid) begin
                skid_valid_reg <= 1'b1;
            end
        end
        launch_reg.is_insert <= launch_next.is_insert;
        launch_reg.status    <= launch_next.status;
        launch_reg.key       <= launch_next.key;
        launch_reg.addr      <= launch_next.addr;
        launch_reg.remain    <= launch_next.remain;
    end

    // Result payload registers
    always_ff @(posedge aclk) begin
        if (!out_valid_reg || take) begin
            if (skid_valid_reg) begin
                out_reg <= skid_reg;
            end else if (res_valid) begin
                out_reg <= res;
            end
        end else if (res_valid) begin
            skid_reg <= res;
        end
    end

    assign launch_o = launch_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = skat_pkg::M_DATA_W'(out_reg);

endmodule

>>> rtl/core/sorted_key_address_table_top.sv
`timescale 1ns / 1ps
// Top level of the sorted key/address table: controller plus a chain of table cells.
// Depends on skat_pkg, skat_ctrl and skat_cell.
//
// Usage:
//   s_ channel carries one item: insert (s_tuser = 0) of key and address, or
//   lookup (s_tuser = 1) of key. m_ channel returns one result per item with
//   status, found address and entry count after the item.
//   max_entries is written over the APB port at byte address 0; the user must write it
//   only while idle, which the block itself does not enforce.
// Path: an accepted item's token is registered in the launch register, then walks the
//   cell chain one slot per cycle; the result is registered in the output stage.
// Flow: s_tready drops after each accepted item until its token leaves the last cell.
// Stall: a finished result waits in the output register; a second one waits in
//   a skid register, and no new item is taken while the skid register is full.
// Reset: synchronous, active low; clears the entry count, sets max_entries to 64,
//   and empties the chain and output stage. Slot contents are not cleared.
module sorted_key_address_table_top (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [skat_pkg::S_DATA_W-1:0]    s_tdata,   // key[31:0], entry_address[95:32]
    input  logic                             s_tuser,   // action
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [skat_pkg::M_DATA_W-1:0]    m_tdata,   // status[2:0], found_address[66:3],
                                                        // entry_count[73:67], zero[79:74]
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [skat_pkg::PADDR_W-1:0]     paddr,
    input  logic [skat_pkg::PDATA_W-1:0]     pwdata,
    output logic [skat_pkg::PDATA_W-1:0]     prdata,
    output logic                             pready
);

    skat_pkg::tok_t tok [skat_pkg::CAPACITY+1];

    skat_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .launch_o  (tok[0]),
        .tok_end_i (tok[skat_pkg::CAPACITY])
    );

    // Chain of table slots, slot 0 holds the smallest key
    for (genvar i = 0; i < skat_pkg::CAPACITY; i++) begin : g_cell
        skat_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .tok_i   (tok[i]),
            .tok_o   (tok[i+1])
        );
    end

endmodule

>>> rtl/core/skat_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the sorted key/address table, bound to the top level.
// Depends on skat_pkg.
module skat_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [skat_pkg::M_DATA_W-1:0]    m_tdata
);

    logic [skat_pkg::STAT_W-1:0] status;
    logic [skat_pkg::ADDR_W-1:0] found;
    logic [skat_pkg::OCNT_W-1:0] count;

    assign status = m_tdata[skat_pkg::STAT_W-1:0];
    assign found  = m_tdata[skat_pkg::STAT_W +: skat_pkg::ADDR_W];
    assign count  = m_tdata[skat_pkg::STAT_W+skat_pkg::ADDR_W +: skat_pkg::OCNT_W];

    // A stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // One item in flight: no new item right after one is taken
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("item accepted while another is in flight");

    // Status is a defined code
    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> status == skat_pkg::ST_OK || status == skat_pkg::ST_FULL ||
                     status == skat_pkg::ST_DUP || status == skat_pkg::ST_EMPTY ||
                     status == skat_pkg::ST_MISSING)
        else $error("undefined status code");

    // Only a successful lookup carries an address
    a_found_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && status != skat_pkg::ST_OK |-> found == '0)
        else $error("address returned on a failed item");

    // Entry count never exceeds the table size
    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> count <= skat_pkg::OCNT_W'(skat_pkg::CAPACITY))
        else $error("entry count beyond capacity");

endmodule

bind sorted_key_address_table_top skat_checker u_skat_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

>>> tb/sv/sorted_key_address_table_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for sorted_key_address_table_top: stream items in, one result out,
// checked against a behavioral table kept in a small scoreboard class.
// Depends on skat_pkg and the top-level RTL only.
module sorted_key_address_table_top_tb;

    localparam int IDLE_LIMIT = 2000;
    localparam int TAIL_WAIT  = 2 * skat_pkg::CAPACITY + 10;
    // Index past the register list
    localparam logic [skat_pkg::PADDR_W-3:0] REG_SPARE = 1'b1;

    // Behavioral table plus the queue of results it predicts
    class table_scoreboard;
        logic [skat_pkg::KEY_W-1:0]  key_slots  [skat_pkg::CAPACITY];
        logic [skat_pkg::ADDR_W-1:0] addr_slots [skat_pkg::CAPACITY];
        int unsigned                 fill;
        int unsigned                 limit;
        skat_pkg::res_t              due_results [$];
        int unsigned                 failures;

        function new();
            fill     = 0;
            limit    = skat_pkg::MAX_ENTRIES_RST;
            failures = 0;
        endfunction

        function void write_reg(logic [skat_pkg::PADDR_W-3:0] idx,
                                logic [skat_pkg::PDATA_W-1:0] value);
            if (idx == skat_pkg::REG_MAX_ENTRIES)
                limit = value[skat_pkg::CFG_W-1:0];
        endfunction

        // Refuse when full or duplicate, else open a gap at the sorted position
        function logic [skat_pkg::STAT_W-1:0] insert_pair(logic [skat_pkg::KEY_W-1:0] k,
                                                          logic [skat_pkg::ADDR_W-1:0] a);
            int unsigned eff;
            int unsigned pos;
            int          i;
            eff = (limit > skat_pkg::CAPACITY) ? skat_pkg::CAPACITY : limit;
            if (fill >= eff || fill >= skat_pkg::CAPACITY)
                return skat_pkg::ST_FULL;
            pos = fill;
            for (i = 0; i < fill; i++) begin
                if (key_slots[i] == k)
                    return skat_pkg::ST_DUP;
                if (key_slots[i] > k) begin
                    pos = i;
                    break;
                end
            end
            for (i = fill; i > pos; i--) begin
                key_slots[i]  = key_slots[i-1];
                addr_slots[i] = addr_slots[i-1];
            end
            key_slots[pos]  = k;
            addr_slots[pos] = a;
            fill++;
            return skat_pkg::ST_OK;
        endfunction

        function void note_item(logic act, logic [skat_pkg::KEY_W-1:0] k,
                                logic [skat_pkg::ADDR_W-1:0] a);
            skat_pkg::res_t r;
            int             i;
            r = '0;
            if (act == skat_pkg::ACT_INSERT) begin
                r.status = insert_pair(k, a);
            end else if (fill == 0) begin
                r.status = skat_pkg::ST_EMPTY;
            end else begin
                r.status = skat_pkg::ST_MISSING;
                for (i = 0; i < fill; i++) begin
                    if (key_slots[i] == k) begin
                        r.status = skat_pkg::ST_OK;
                        r.found  = addr_slots[i];
                        break;
                    end
                end
            end
            r.count = skat_pkg::OCNT_W'(fill);
            due_results.push_back(r);
        endfunction

        function void report(string msg);
            failures++;
            if (failures <= 10)
                $display("%s", msg);
        endfunction

        function void check_result(logic [skat_pkg::M_DATA_W-1:0] d);
            skat_pkg::res_t want;
            skat_pkg::res_t got;
            got = d[$bits(skat_pkg::res_t)-1:0];
            if (due_results.size() == 0) begin
                report($sformatf("unexpected result item %h", d));
                return;
            end
            want = due_results.pop_front();
            if (got.status !== want.status || got.found !== want.found
                    || got.count !== want.count)
                report($sformatf({"result mismatch: expected status %0d found %h count %0d,",
                                  " got status %0d found %h count %0d"},
                                 want.status, want.found, want.count,
                                 got.status, got.found, got.count));
        endfunction

        function int unsigned pending();
            return due_results.size();
        endfunction

        function void close();
            if (due_results.size() != 0)
                report($sformatf("%0d results never arrived", due_results.size()));
        endfunction

        // Pick a key already in the table, or any key while it is empty
        function logic [skat_pkg::KEY_W-1:0] held_key();
            if (fill == 0)
                return $urandom;
            return key_slots[$urandom_range(fill - 1)];
        endfunction
    endclass

    logic                            aclk     = 1'b0;
    logic                            aresetn  = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [skat_pkg::S_DATA_W-1:0]   s_tdata  = '0;   // key[31:0], entry_address[95:32]
    logic                            s_tuser  = 1'b0; // action
    logic                            m_tvalid;
    logic                            m_tready = 1'b1;
    logic [skat_pkg::M_DATA_W-1:0]   m_tdata;         // status[2:0], found_address[66:3],
                                                      // entry_count[73:67], zero[79:74]
    logic                            psel     = 1'b0;
    logic                            penable  = 1'b0;
    logic                            pwrite   = 1'b0;
    logic [skat_pkg::PADDR_W-1:0]    paddr    = '0;
    logic [skat_pkg::PDATA_W-1:0]    pwdata   = '0;
    logic [skat_pkg::PDATA_W-1:0]    prdata;
    logic                            pready;

    table_scoreboard sb = new();
    bit              idle_en     = 1'b1;
    int              stall_left  = 0;
    int              idle_cycles = 0;

    sorted_key_address_table_top u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Stall the result channel in bursts of random length while idling is enabled
    always @(negedge aclk) begin
        if (idle_en && stall_left != 0) begin
            m_tready   = 1'b0;
            stall_left = stall_left - 1;
        end else if (idle_en && $urandom_range(9) == 0) begin
            m_tready   = 1'b0;
            stall_left = $urandom_range(5);
        end else begin
            m_tready = 1'b1;
        end
    end

    // Check results, note accepted items, and watch for a hang
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata);
            if (s_tvalid && s_tready)
                sb.note_item(s_tuser, s_tdata[skat_pkg::KEY_W-1:0],
                             s_tdata[skat_pkg::KEY_W+skat_pkg::ADDR_W-1:skat_pkg::KEY_W]);
            if ((m_tvalid && m_tready) || (s_tvalid && s_tready) || (psel && penable))
                idle_cycles = 0;
            else
                idle_cycles = idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // Offer one item and hold it until taken; starts and ends just after a falling edge
    task automatic send_item(logic act, logic [skat_pkg::KEY_W-1:0] k,
                             logic [skat_pkg::ADDR_W-1:0] a);
        int gap;
        if (idle_en && $urandom_range(2) == 0) begin
            gap      = $urandom_range(1, 6);
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = act;
        s_tdata  = {a, k};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    // Stop offering and wait for every outstanding result
    task automatic drain();
        s_tvalid = 1'b0;
        while (sb.pending() != 0)
            @(negedge aclk);
    endtask

    task automatic write_reg(logic [skat_pkg::PADDR_W-3:0] idx,
                             logic [skat_pkg::PDATA_W-1:0] value);
        drain();
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        sb.write_reg(idx, value);
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    function automatic logic [skat_pkg::KEY_W-1:0] rand_key();
        int sel;
        sel = $urandom_range(9);
        case (sel)
            0, 1, 2, 3: return sb.held_key();
            4, 5:       return $urandom_range(255);
            6:          return ($urandom_range(1) != 0) ? '1 : '0;
            7:          return sb.held_key() + (($urandom_range(1) != 0) ? 1 : -1);
            default:    return $urandom;
        endcase
    endfunction

    function automatic logic [skat_pkg::ADDR_W-1:0] rand_addr();
        int sel;
        sel = $urandom_range(7);
        case (sel)
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic run_random(int n);
        repeat (n)
            send_item(logic'($urandom_range(1)), rand_key(), rand_addr());
    endtask

    initial begin
        int unsigned low_limit;

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Lookups on an empty table
        send_item(skat_pkg::ACT_LOOKUP, '0, '1);
        send_item(skat_pkg::ACT_LOOKUP, '1, '0);

        // Zero limit refuses every insert; a spare register index is ignored
        write_reg(skat_pkg::REG_MAX_ENTRIES, 32'd0);
        send_item(skat_pkg::ACT_INSERT, 32'd5, 64'h1234_5678_9abc_def0);
        write_reg(REG_SPARE, 32'd7);
        send_item(skat_pkg::ACT_INSERT, 32'd6, 64'h0fed_cba9_8765_4321);

        // Limit of one entry
        write_reg(skat_pkg::REG_MAX_ENTRIES, 32'd1);
        send_item(skat_pkg::ACT_INSERT, '1, '1);
        send_item(skat_pkg::ACT_INSERT, '0, '0);

        // Only the low bits of the write count: limit becomes three
        write_reg(skat_pkg::REG_MAX_ENTRIES, 32'hffff_ff83);
        send_item(skat_pkg::ACT_INSERT, '0, '0);
        send_item(skat_pkg::ACT_INSERT, 32'd100, 64'hdead_beef_cafe_f00d);
        send_item(skat_pkg::ACT_INSERT, 32'd50, 64'h5555_aaaa_5555_aaaa);
        // Full table with a key already present reports full
        send_item(skat_pkg::ACT_INSERT, '0, 64'h1);
        send_item(skat_pkg::ACT_LOOKUP, '0, '1);
        send_item(skat_pkg::ACT_LOOKUP, '1, '0);
        send_item(skat_pkg::ACT_LOOKUP, 32'd100, '0);
        send_item(skat_pkg::ACT_LOOKUP, 32'd7, '0);

        // Oversized limit clamps to capacity; duplicate, then a middle insert
        write_reg(skat_pkg::REG_MAX_ENTRIES, 32'd127);
        send_item(skat_pkg::ACT_INSERT, 32'd100, 64'h2);
        send_item(skat_pkg::ACT_INSERT, 32'd50, 64'h5555_aaaa_5555_aaaa);
        send_item(skat_pkg::ACT_LOOKUP, 32'd50, '0);

        // Partial fill, then a limit below the count, then fill to capacity
        write_reg(skat_pkg::REG_MAX_ENTRIES, 32'd40);
        run_random(250);
        low_limit = (sb.fill > 1) ? $urandom_range(sb.fill - 1, 1) : 1;
        write_reg(skat_pkg::REG_MAX_ENTRIES, low_limit);
        run_random(300);
        write_reg(skat_pkg::REG_MAX_ENTRIES, 32'd64);
        run_random(300);

        // Last stretch without idling on either side
        write_reg(skat_pkg::REG_MAX_ENTRIES, 32'd127);
        idle_en = 1'b0;
        run_random(400);

        drain();
        repeat (TAIL_WAIT) @(negedge aclk);
        sb.close();
        if (sb.failures == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
